### design/afe_pkg.sv
// Shared types and constants for the aging FIFO expiry block.
// Used by afe_front, afe_back and aging_fifo_expiry_core; no dependencies.
package afe_pkg;

  localparam int AFE_QUEUE_DEPTH = 16;
  localparam int AFE_MAX_POPS    = 16;
  localparam int AFE_DATA_W      = 32;
  localparam int AFE_DUR_W       = 16;
  localparam int AFE_CMDQ_DEPTH  = 2;

  localparam logic [AFE_DUR_W-1:0] AFE_RESET_DURATION = 16'd5;

  // Configuration register index (word address)
  localparam logic REG_EXPIRY_DURATION = 1'b0;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_EXPIRE = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  is_tick;
    logic [AFE_DATA_W-1:0] value;
  } cmd_t;

endpackage

### design/afe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/afe_front.sv
// Front end: accepts input beats, decodes the request type and holds
// them in a two-entry command queue. Depends on afe_pkg.
module afe_front import afe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [AFE_DATA_W-1:0] in_tdata,   // [31:0] item_value
  input  logic                  in_tuser,   // [0] req_type
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  cmd_t       q_r [AFE_CMDQ_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'(AFE_CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  assign push = in_tvalid && in_tready;
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{is_tick: in_tuser, value: in_tdata};
    end
  end

endmodule

### design/afe_back.sv
// Back end: entry store, time count, expiry sequencer and output register.
// Depends on afe_pkg and afe_ram.
module afe_back import afe_pkg::*; #(
  parameter int QUEUE_DEPTH = AFE_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  input  logic [AFE_DUR_W-1:0]  duration,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*AFE_DATA_W-1:0] out_tdata,
  output kind_t                 out_tuser,
  output logic                  out_tlast
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int POP_W  = $clog2(AFE_MAX_POPS + 1);
  localparam int ENTRY_W = 2 * AFE_DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AFE_DATA_W-1:0] time_r, time_nxt;
  logic [POP_W-1:0]      pops_r, pops_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [AFE_DATA_W-1:0] pend_value_r, pend_value_nxt;
  logic [AFE_DATA_W-1:0] pend_age_r, pend_age_nxt;

  logic                  out_valid_r, out_valid_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic [AFE_DATA_W-1:0] out_value_r, out_value_nxt;
  logic [AFE_DATA_W-1:0] out_age_r, out_age_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [AFE_DATA_W-1:0] rd_value, rd_stamp, rd_age;
  logic                  expired;

  // entry layout: stamp in the upper word, value in the lower
  afe_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({time_r, cmd.value}),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign rd_value = ram_rdata[AFE_DATA_W-1:0];
  assign rd_stamp = ram_rdata[ENTRY_W-1:AFE_DATA_W];
  assign rd_age   = time_r - rd_stamp;
  assign expired  = rd_age > {{(AFE_DATA_W-AFE_DUR_W){1'b0}}, duration};

  assign out_free  = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == ST_IDLE) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_age_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    time_nxt       = time_r;
    pops_nxt       = pops_r;
    pend_vld_nxt   = pend_vld_r;
    pend_value_nxt = pend_value_r;
    pend_age_nxt   = pend_age_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    out_age_nxt    = out_age_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          if (!cmd.is_tick) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = cmd.value;
            out_age_nxt   = '0;
            out_last_nxt  = 1'b1;
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              out_kind_nxt = KIND_DROP;
            end else begin
              out_kind_nxt = KIND_ACCEPT;
              ram_we       = 1'b1;
              tail_nxt     = ptr_inc(tail_r);
              count_nxt    = count_r + 1'b1;
            end
          end else begin
            time_nxt     = time_r + 1'b1;
            pops_nxt     = '0;
            pend_vld_nxt = 1'b0;
            if (count_r != '0) begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        // head entry lands in the RAM output register this cycle
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (expired) begin
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_EXPIRE;
              out_value_nxt = pend_value_r;
              out_age_nxt   = pend_age_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt   = 1'b1;
            pend_value_nxt = rd_value;
            pend_age_nxt   = rd_age;
            head_nxt       = ptr_inc(head_r);
            count_nxt      = count_r - 1'b1;
            pops_nxt       = pops_r + 1'b1;
            if (count_r == CNT_W'(1) || pops_r == POP_W'(AFE_MAX_POPS - 1)) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end else begin
          state_nxt = pend_vld_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRE;
          out_value_nxt = pend_value_r;
          out_age_nxt   = pend_age_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      time_r      <= '0;
      pops_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      pops_r      <= pops_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_value_r <= pend_value_nxt;
    pend_age_r   <= pend_age_nxt;
    out_kind_r   <= out_kind_nxt;
    out_value_r  <= out_value_nxt;
    out_age_r    <= out_age_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### design/aging_fifo_expiry_core.sv
// Aging FIFO with expiry. Enqueue: via the command queue and output register;
// one enqueue per cycle sustained while the output is taken and no tick is
// in progress. Tick: bumps the time count; on a non-empty queue each head
// entry gets a registered read of the entry store, then an age compare, and
// the last pop is flushed. Sync active-low reset empties the queue, clears the
// time count, sets duration to 5. Depends on afe_pkg, afe_front, afe_back.
module aging_fifo_expiry_core import afe_pkg::*; #(
  parameter int QUEUE_DEPTH = AFE_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [AFE_DATA_W-1:0]   in_tdata,    // [31:0] item_value
  input  logic                    in_tuser,    // [0] req_type
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [2*AFE_DATA_W-1:0] out_tdata,   // [31:0] out_value, [63:32] entry_age
  output logic [1:0]              out_tuser,   // [1:0] result_kind
  output logic                    out_tlast,   // last_of_run
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic                 cmd_valid, cmd_ready;
  cmd_t                 cmd;
  logic [AFE_DUR_W-1:0] duration_r;
  kind_t                out_kind;
  logic                 cfg_wr;
  logic                 cfg_sel_dur;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_dur = (cfg_paddr[2] == REG_EXPIRY_DURATION);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_dur;
  assign cfg_prdata  = cfg_sel_dur ? {{(32-AFE_DUR_W){1'b0}}, duration_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= AFE_RESET_DURATION;
    end else if (cfg_wr) begin
      duration_r <= cfg_pwdata[AFE_DUR_W-1:0];
    end
  end

  afe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  afe_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .duration   (duration_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_kind),
    .out_tlast  (out_tlast)
  );

  assign out_tuser = out_kind;

endmodule
